// ===== design/pdfp_pkg.sv =====
// Shared types and constants for the pipe-delimited frame parser.
`default_nettype none
package pdfp_pkg;

    localparam logic [7:0] SEP_BYTE   = 8'h7C;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [15:0] LEN_MAX   = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_CODE     = 3'd0,
        PH_SEP      = 3'd1,
        PH_LEN      = 3'd2,
        PH_PAYLOAD  = 3'd3,
        PH_DONE_OK  = 3'd4,
        PH_DONE_BAD = 3'd5
    } phase_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    // Work handed from the classifier to the emitter for one accepted byte.
    typedef struct packed {
        logic        emit_sep;
        logic        emit_byte;
        logic        emit_status;
        logic [7:0]  data;
        logic [7:0]  code;
        logic [15:0] length;
        logic        valid;
    } job_t;

endpackage
`default_nettype wire

// ===== design/pdfp_rx_if.sv =====
// Input channel: received bytes with end-of-buffer flag.
`default_nettype none
interface pdfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_buffer;

    modport source (output valid, output rx_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface
`default_nettype wire

// ===== design/pdfp_res_if.sv =====
// Output channel: payload bytes and end-of-buffer status.
`default_nettype none
interface pdfp_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  payload;
    logic [7:0]  frame_code;
    logic [15:0] declared_length;
    logic        frame_valid;
    logic        last;

    modport source (output valid, output kind, output payload, output frame_code,
                    output declared_length, output frame_valid, output last,
                    input ready);
    modport sink   (input valid, input kind, input payload, input frame_code,
                    input declared_length, input frame_valid, input last,
                    output ready);
endinterface
`default_nettype wire

// ===== design/pipe_delimited_frame_parser.sv =====
// Top level of the pipe-delimited frame parser.
//
//  channel  | dir | payload                                            | accepted when
//  ---------+-----+----------------------------------------------------+-----------------
//  rx       | in  | rx_byte, end_of_buffer                             | valid && ready
//  result   | out | kind, payload, frame_code, declared_length,        | valid && ready
//           |     | frame_valid, last                                  |
//
// One byte is accepted per cycle while the job queue has room; the parser state
// updates in that same cycle. The emitter issues one result per cycle from its
// output register while the receiver is ready; the queue of QUEUE_DEPTH jobs
// absorbs bursts. Each result passes through the queue and the output register.
// rst_n clears parser state, queue and output valid at once.
`default_nettype none
module pipe_delimited_frame_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pdfp_rx_if.sink    rx,
    pdfp_res_if.source result
);

    pdfp_pkg::job_t push_job, head_job;
    logic           push, push_ready, head_valid, pop;

    pdfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .job       (push_job),
        .job_push  (push),
        .job_ready (push_ready)
    );

    pdfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_job   (push_job),
        .push       (push),
        .push_ready (push_ready),
        .head_job   (head_job),
        .head_valid (head_valid),
        .pop        (pop)
    );

    pdfp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_job   (head_job),
        .head_valid (head_valid),
        .pop        (pop),
        .result     (result)
    );

endmodule
`default_nettype wire

// ===== design/pdfp_front.sv =====
// Front end: parser state machine, turns each byte into an emit job.
`default_nettype none
module pdfp_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    pdfp_rx_if.sink            rx,
    output pdfp_pkg::job_t     job,
    output logic               job_push,
    input  wire logic          job_ready
);

    pdfp_pkg::phase_t phase_reg, phase_next;
    logic             held_reg, held_next;
    logic [7:0]       code_reg, code_next;
    logic [15:0]      len_reg, len_next;

    logic        accept;
    logic        is_sep;
    logic [19:0] len_sum;
    logic [19:0] len_diff;
    logic [15:0] len_clamped;

    assign rx.ready = job_ready;
    assign accept   = rx.valid && job_ready;
    assign is_sep   = (rx.rx_byte == pdfp_pkg::SEP_BYTE);

    // acc*10 + byte, then subtract '0' with clamping to 0..65535
    assign len_sum  = {1'b0, len_reg, 3'b000} + {3'b000, len_reg, 1'b0}
                      + {12'd0, rx.rx_byte};
    assign len_diff = len_sum - {12'd0, pdfp_pkg::DIGIT_ZERO};

    always_comb
    begin
        if (len_sum < {12'd0, pdfp_pkg::DIGIT_ZERO})
            len_clamped = 16'd0;
        else if (len_diff[19:16] != 4'd0)
            len_clamped = pdfp_pkg::LEN_MAX;
        else
            len_clamped = len_diff[15:0];
    end

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        code_next  = code_reg;
        len_next   = len_reg;
        job        = '0;
        job.data   = rx.rx_byte;

        unique case (phase_reg)
            pdfp_pkg::PH_CODE:
            begin
                code_next  = rx.rx_byte;
                phase_next = pdfp_pkg::PH_SEP;
            end
            pdfp_pkg::PH_SEP:
            begin
                phase_next = is_sep ? pdfp_pkg::PH_LEN : pdfp_pkg::PH_DONE_BAD;
            end
            pdfp_pkg::PH_LEN:
            begin
                if (is_sep)
                    phase_next = pdfp_pkg::PH_PAYLOAD;
                else
                    len_next = len_clamped;
            end
            pdfp_pkg::PH_PAYLOAD:
            begin
                if (held_reg && is_sep)
                begin
                    // terminator found
                    held_next  = 1'b0;
                    phase_next = pdfp_pkg::PH_DONE_OK;
                end
                else
                begin
                    job.emit_sep  = held_reg;
                    held_next     = is_sep;
                    job.emit_byte = !is_sep;
                end
            end
            default:
            begin
            end
        endcase

        if (rx.end_of_buffer)
        begin
            job.emit_status = 1'b1;
            job.code        = code_next;
            job.length      = len_next;
            job.valid       = (phase_next == pdfp_pkg::PH_DONE_OK);
            phase_next      = pdfp_pkg::PH_CODE;
            held_next       = 1'b0;
            code_next       = 8'd0;
            len_next        = 16'd0;
        end
    end

    assign job_push = accept && (job.emit_sep || job.emit_byte || job.emit_status);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pdfp_pkg::PH_CODE;
            held_reg  <= 1'b0;
            code_reg  <= 8'd0;
            len_reg   <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            code_reg  <= code_next;
            len_reg   <= len_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/pdfp_queue.sv =====
// Small job queue between the parser front end and the emitter.
`default_nettype none
module pdfp_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire pdfp_pkg::job_t push_job,
    input  wire logic           push,
    output logic                push_ready,
    output pdfp_pkg::job_t      head_job,
    output logic                head_valid,
    input  wire logic           pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pdfp_pkg::job_t   slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slots_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_job;
    end

endmodule
`default_nettype wire

// ===== design/pdfp_back.sv =====
// Back end: expands each job into one to three result transactions.
`default_nettype none
module pdfp_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire pdfp_pkg::job_t head_job,
    input  wire logic           head_valid,
    output logic                pop,
    pdfp_res_if.source          result
);

    logic [2:0]  done_reg, done_next;
    logic [2:0]  sel;
    logic        pend_sep, pend_byte, pend_stat;
    logic        remaining;
    logic        out_free, load;

    logic        valid_reg;
    logic        kind_reg, kind_next;
    logic [7:0]  payload_reg, payload_next;
    logic [7:0]  code_reg, code_next;
    logic [15:0] len_reg, len_next;
    logic        fvalid_reg, fvalid_next;
    logic        last_reg;

    assign pend_sep  = head_job.emit_sep    && !done_reg[0];
    assign pend_byte = head_job.emit_byte   && !done_reg[1];
    assign pend_stat = head_job.emit_status && !done_reg[2];

    assign out_free = !valid_reg || result.ready;
    assign load     = head_valid && out_free;

    // order within a job: held separator, byte, status
    always_comb
    begin
        kind_next    = pdfp_pkg::KIND_PAYLOAD;
        payload_next = 8'd0;
        code_next    = 8'd0;
        len_next     = 16'd0;
        fvalid_next  = 1'b0;
        if (pend_sep)
        begin
            sel          = 3'b001;
            payload_next = pdfp_pkg::SEP_BYTE;
            remaining    = pend_byte || pend_stat;
        end
        else if (pend_byte)
        begin
            sel          = 3'b010;
            payload_next = head_job.data;
            remaining    = pend_stat;
        end
        else
        begin
            sel          = 3'b100;
            kind_next    = pdfp_pkg::KIND_STATUS;
            code_next    = head_job.code;
            len_next     = head_job.length;
            fvalid_next  = head_job.valid;
            remaining    = 1'b0;
        end
    end

    assign pop       = load && !remaining;
    assign done_next = pop ? 3'b000 : (done_reg | sel);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 3'b000;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                done_reg <= done_next;
            if (out_free)
                valid_reg <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg    <= kind_next;
            payload_reg <= payload_next;
            code_reg    <= code_next;
            len_reg     <= len_next;
            fvalid_reg  <= fvalid_next;
            last_reg    <= !remaining;
        end
    end

    assign result.valid           = valid_reg;
    assign result.kind            = kind_reg;
    assign result.payload         = payload_reg;
    assign result.frame_code      = code_reg;
    assign result.declared_length = len_reg;
    assign result.frame_valid     = fvalid_reg;
    assign result.last            = last_reg;

endmodule
`default_nettype wire

// ===== bench/pdfp_checker.sv =====
`timescale 1ns / 1ps
// Checker for the frame parser: predicts results from accepted bytes and compares them.
module pdfp_checker
    import pdfp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    pdfp_rx_if   rx,
    pdfp_res_if  result,
    output int   fail_count,
    output int   pending,
    output int   results_seen,
    output int   status_seen
);

    typedef struct {
        kind_t       kind;
        logic [7:0]  payload;
        logic [7:0]  code;
        logic [15:0] length;
        logic        valid;
        logic        last;
    } parse_result_t;

    // predictor state
    phase_t      phase    = PH_CODE;
    logic        sep_held = 1'b0;
    logic [7:0]  code_q   = '0;
    logic [15:0] len_acc  = '0;

    parse_result_t due_results[$];
    parse_result_t want;

    int n_fail    = 0;
    int n_due     = 0;
    int n_results = 0;
    int n_status  = 0;

    assign fail_count   = n_fail;
    assign pending      = n_due;
    assign results_seen = n_results;
    assign status_seen  = n_status;

    task automatic push_result(input kind_t k, input logic [7:0] pay, input logic [7:0] code,
                               input logic [15:0] len, input logic ok);
        parse_result_t r;
        r.kind    = k;
        r.payload = pay;
        r.code    = code;
        r.length  = len;
        r.valid   = ok;
        r.last    = 1'b0;
        due_results.push_back(r);
    endtask

    task automatic deframe_byte(input logic [7:0] b, input logic eob);
        int   v;
        int   n_before;
        logic ended;
        n_before = due_results.size();
        ended    = 1'b0;
        case (phase)
            PH_CODE:
            begin
                code_q = b;
                phase  = PH_SEP;
            end
            PH_SEP:
                phase = (b == SEP_BYTE) ? PH_LEN : PH_DONE_BAD;
            PH_LEN:
            begin
                if (b == SEP_BYTE)
                    phase = PH_PAYLOAD;
                else
                begin
                    // non-digits go through the same sum, then clamp
                    v = int'(len_acc) * 10 + int'(b) - int'(DIGIT_ZERO);
                    if (v < 0)
                        v = 0;
                    if (v > int'(LEN_MAX))
                        v = int'(LEN_MAX);
                    len_acc = v[15:0];
                end
            end
            PH_PAYLOAD:
            begin
                if (sep_held)
                begin
                    sep_held = 1'b0;
                    if (b == SEP_BYTE)
                    begin
                        phase = PH_DONE_OK;
                        ended = 1'b1;
                    end
                    else
                        push_result(KIND_PAYLOAD, SEP_BYTE, '0, '0, 1'b0);
                end
                if (!ended)
                begin
                    if (b == SEP_BYTE)
                        sep_held = 1'b1;
                    else
                        push_result(KIND_PAYLOAD, b, '0, '0, 1'b0);
                end
            end
            default: ;
        endcase
        if (eob)
        begin
            push_result(KIND_STATUS, '0, code_q, len_acc, phase == PH_DONE_OK);
            phase    = PH_CODE;
            sep_held = 1'b0;
            code_q   = '0;
            len_acc  = '0;
        end
        if (due_results.size() > n_before)
            due_results[due_results.size() - 1].last = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
            n_fail++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase    = PH_CODE;
            sep_held = 1'b0;
            code_q   = '0;
            len_acc  = '0;
            due_results.delete();
            n_due    = 0;
        end
        else
        begin
            // results trail their byte through the job queue and the output register, so order here is free
            if (result.valid && result.ready)
            begin
                n_results++;
                if (due_results.size() == 0)
                begin
                    $error("unexpected result transaction: kind %0d payload %0h",
                           result.kind, result.payload);
                    n_fail++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (want.kind == KIND_STATUS)
                        n_status++;
                    check_field("kind", 16'(want.kind), 16'(result.kind));
                    check_field("payload", 16'(want.payload), 16'(result.payload));
                    check_field("frame_code", 16'(want.code), 16'(result.frame_code));
                    check_field("declared_length", want.length, result.declared_length);
                    check_field("frame_valid", 16'(want.valid), 16'(result.frame_valid));
                    check_field("last", 16'(want.last), 16'(result.last));
                end
            end
            if (rx.valid && rx.ready)
                deframe_byte(rx.rx_byte, rx.end_of_buffer);
            n_due = due_results.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the frame parser: clock, reset, byte stimulus and verdict.
module tb_top;
    import pdfp_pkg::*;

    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_BYTES = 100;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    pdfp_rx_if  rx_ch ();
    pdfp_res_if res_ch ();

    int fail_count;
    int pending;
    int results_seen;
    int status_seen;

    int   idle_pct   = 0;
    int   stall_pct  = 0;
    logic start_hold = 1'b0;
    logic hold_ready = 1'b0;

    logic [7:0] buf_bytes[$];
    int bytes_sent   = 0;
    int buffers_sent = 0;

    pipe_delimited_frame_parser u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch)
    );

    pdfp_checker u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx           (rx_ch),
        .result       (res_ch),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .status_seen  (status_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off when asked
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_ready)
                res_ch.ready <= 1'b0;
            else
                res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin
        wait (start_hold);
        @(posedge clk);
        hold_ready = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_ready = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    task automatic send_buffer();
        int i;
        for (i = 0; i < buf_bytes.size(); i++)
        begin
            while ($urandom_range(0, 99) < idle_pct)
            begin
                rx_ch.valid <= 1'b0;
                @(negedge clk);
            end
            rx_ch.valid         <= 1'b1;
            rx_ch.rx_byte       <= buf_bytes[i];
            rx_ch.end_of_buffer <= (i == buf_bytes.size() - 1);
            do
                @(posedge clk);
            while (!rx_ch.ready);
            @(negedge clk);
            bytes_sent++;
        end
        buffers_sent++;
    endtask

    // core counts the bytes the parser actually acts on
    task automatic build_random_buffer(output int core);
        int         pick;
        int         style;
        int         n;
        int         i;
        logic       prev_sep;
        logic [7:0] b;
        buf_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            n = $urandom_range(1, 10);
            for (i = 0; i < n; i++)
                buf_bytes.push_back(8'($urandom_range(0, 255)));
            core = n;
        end
        else if (pick < 18)
        begin
            // bad separator, rest of buffer ignored
            buf_bytes.push_back(8'($urandom_range(0, 255)));
            do
                b = 8'($urandom_range(0, 255));
            while (b == SEP_BYTE);
            buf_bytes.push_back(b);
            n = $urandom_range(0, 4);
            for (i = 0; i < n; i++)
                buf_bytes.push_back(8'($urandom_range(0, 255)));
            core = 2;
        end
        else
        begin
            buf_bytes.push_back(8'($urandom_range(0, 255)));
            buf_bytes.push_back(SEP_BYTE);
            style = $urandom_range(0, 9);
            n = (style == 0) ? 0 : (style < 7) ? $urandom_range(1, 3) : $urandom_range(5, 6);
            for (i = 0; i < n; i++)
            begin
                b = DIGIT_ZERO + 8'($urandom_range(0, 9));
                if (style == 9 && i == n / 2)
                begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == SEP_BYTE);
                end
                buf_bytes.push_back(b);
            end
            buf_bytes.push_back(SEP_BYTE);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(0, 8);
            prev_sep = 1'b0;
            for (i = 0; i < n; i++)
            begin
                b = ($urandom_range(0, 99) < 15) ? SEP_BYTE : 8'($urandom_range(0, 255));
                // a second '|' here would end the frame early
                if (prev_sep && b == SEP_BYTE)
                    b = 8'($urandom_range(0, SEP_BYTE - 1));
                prev_sep = (b == SEP_BYTE);
                buf_bytes.push_back(b);
            end
            buf_bytes.push_back(SEP_BYTE);
            if (pick >= 26)
                buf_bytes.push_back(SEP_BYTE);
            core = buf_bytes.size();
            if (pick >= 26 && pick < 36)
            begin
                n = $urandom_range(1, buf_bytes.size() - 1);
                while (buf_bytes.size() > n)
                    void'(buf_bytes.pop_back());
                core = n;
            end
            else if (pick >= 36 && $urandom_range(0, 2) == 0)
            begin
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++)
                    buf_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        int p;
        int core;
        int cnt;
        rx_ch.valid         = 1'b0;
        rx_ch.rx_byte       = '0;
        rx_ch.end_of_buffer = 1'b0;
        rst_n               = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // one-byte buffer: short, code only
        buf_bytes = '{8'h00};
        send_buffer();
        // saturating length, payload extremes, lone separator, good terminator
        buf_bytes = '{8'hFF, SEP_BYTE, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39, SEP_BYTE,
                      8'hFF, SEP_BYTE, 8'h00, SEP_BYTE, SEP_BYTE};
        send_buffer();
        // bad separator
        buf_bytes = '{8'h5A, 8'h00, 8'h78};
        send_buffer();
        // non-digits in the length, then a final '|'
        buf_bytes = '{8'h63, SEP_BYTE, 8'h00, 8'hFF, SEP_BYTE, 8'h71, SEP_BYTE};
        send_buffer();

        for (p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    idle_pct   = 0;
                    stall_pct  = 0;
                    start_hold = 1'b1;
                end
                1:
                begin
                    idle_pct  = 58;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 58;
                end
                default:
                begin
                    idle_pct  = 10;
                    stall_pct = 10;
                end
            endcase
            cnt = 0;
            while (cnt < PHASE_BYTES)
            begin
                build_random_buffer(core);
                send_buffer();
                cnt += core;
            end
        end
        rx_ch.valid <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;

        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("tb_top: %0d bytes in %0d buffers sent under four idling mixes",
                 bytes_sent, buffers_sent);
        $display("tb_top: %0d result transactions checked, %0d of them status",
                 results_seen, status_seen);
        if (fail_count == 0 && pending == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
